FILE: hdl/rtcbcd_pkg.sv
`timescale 1ns / 1ps

package rtcbcd_pkg;

    // One input beat: a calendar date and time, binary fields.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_in_item;

    // One result beat: the seven time-block bytes at their field widths.
    typedef struct packed {
        logic [6:0] second_bcd;
        logic [6:0] minute_bcd;
        logic [7:0] hour_code;
        logic [2:0] weekday_bcd;
        logic [5:0] day_bcd;
        logic [4:0] month_bcd;
        logic [7:0] year_bcd;
    } t_out_item;

    localparam logic [11:0] YEAR_BASE      = 12'd2000;
    localparam logic [7:0]  YEAR_BASE_LO   = YEAR_BASE[7:0];

    // Hour byte codes.
    localparam logic [7:0]  HOUR_24_FLAG   = 8'h80;
    localparam logic [7:0]  HOUR_MIDNIGHT  = 8'h12;
    localparam logic [7:0]  HOUR_NOON      = 8'h32;
    localparam logic [7:0]  HOUR_PM_FLAG   = 8'h20;
    localparam logic [7:0]  HOUR_BAD       = 8'h00;
    localparam logic [4:0]  HOUR_TWELVE    = 5'd12;
    localparam logic [4:0]  HOUR_DAY_LEN   = 5'd24;

    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [11:0] WEEKDAY_BIAS   = 12'd5;

    // Days before the first of each month; out-of-range months saturate.
    localparam logic [8:0] MONTH_OFFSET [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
    };

    // bcd(v) = v + 6*(v/10); v/10 as (v*205)>>11, exact below 1029.
    function automatic logic [8:0] f_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  tens;
        prod = {8'd0, v} * 16'd205;
        tens = prod[15:11];
        return {1'b0, v} + 9'({4'd0, tens} * 9'd6);
    endfunction

endpackage

FILE: hdl/rtcbcd_weekday.sv
`timescale 1ns / 1ps

module rtcbcd_weekday (
    input  rtcbcd_pkg::t_in_item i_item,
    output logic [2:0]           o_weekday
);

    logic [11:0] y;
    logic [12:0] y_plus3;
    logic [11:0] leap_days;
    logic        leap_now;
    logic [11:0] count;
    logic [4:0]  fold1;
    logic [3:0]  fold2;

    always_comb begin
        y = (i_item.year >= rtcbcd_pkg::YEAR_BASE) ? (i_item.year - rtcbcd_pkg::YEAR_BASE)
                                                   : i_item.year;
        y_plus3   = {1'b0, y} + 13'd3;
        leap_days = {1'b0, y_plus3[12:2]};
        leap_now  = (i_item.month > rtcbcd_pkg::MONTH_FEB) && (y[1:0] == 2'd0);
        // 365 = 1 mod 7, so 365*y folds to y
        count = {7'd0, i_item.day}
              + {3'd0, rtcbcd_pkg::MONTH_OFFSET[i_item.month]}
              + y + leap_days + rtcbcd_pkg::WEEKDAY_BIAS + {11'd0, leap_now};
        // 8 = 1 mod 7: sum octal digits twice, then one subtract
        fold1 = {2'd0, count[2:0]} + {2'd0, count[5:3]}
              + {2'd0, count[8:6]} + {2'd0, count[11:9]};
        fold2 = {1'b0, fold1[2:0]} + {2'd0, fold1[4:3]};
        o_weekday = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    end

endmodule

FILE: hdl/rtcbcd_fields.sv
`timescale 1ns / 1ps

module rtcbcd_fields (
    input  rtcbcd_pkg::t_in_item  i_item,
    input  logic                  i_hour_24,
    input  logic [2:0]            i_weekday,
    output rtcbcd_pkg::t_out_item o_item
);

    logic [8:0] sec_b;
    logic [8:0] min_b;
    logic [8:0] hour_b;
    logic [8:0] pm_b;
    logic [8:0] day_b;
    logic [8:0] mon_b;
    logic [8:0] year_b;
    logic [7:0] hcode;

    always_comb begin
        sec_b  = rtcbcd_pkg::f_bcd({2'd0, i_item.second});
        min_b  = rtcbcd_pkg::f_bcd({2'd0, i_item.minute});
        hour_b = rtcbcd_pkg::f_bcd({3'd0, i_item.hour});
        pm_b   = rtcbcd_pkg::f_bcd({3'd0, 5'(i_item.hour - rtcbcd_pkg::HOUR_TWELVE)});
        day_b  = rtcbcd_pkg::f_bcd({3'd0, i_item.day});
        mon_b  = rtcbcd_pkg::f_bcd({4'd0, i_item.month});
        year_b = rtcbcd_pkg::f_bcd(i_item.year[7:0] - rtcbcd_pkg::YEAR_BASE_LO);

        priority if (i_hour_24) begin
            hcode = hour_b[7:0] | rtcbcd_pkg::HOUR_24_FLAG;
        end else if (i_item.hour == 5'd0) begin
            hcode = rtcbcd_pkg::HOUR_MIDNIGHT;
        end else if (i_item.hour < rtcbcd_pkg::HOUR_TWELVE) begin
            hcode = hour_b[7:0];
        end else if (i_item.hour == rtcbcd_pkg::HOUR_TWELVE) begin
            hcode = rtcbcd_pkg::HOUR_NOON;
        end else if (i_item.hour < rtcbcd_pkg::HOUR_DAY_LEN) begin
            hcode = pm_b[7:0] | rtcbcd_pkg::HOUR_PM_FLAG;
        end else begin
            hcode = rtcbcd_pkg::HOUR_BAD;
        end

        o_item.second_bcd  = sec_b[6:0];
        o_item.minute_bcd  = min_b[6:0];
        o_item.hour_code   = hcode;
        o_item.weekday_bcd = i_weekday;
        o_item.day_bcd     = day_b[5:0];
        o_item.month_bcd   = mon_b[4:0];
        o_item.year_bcd    = year_b[7:0];
    end

endmodule

FILE: hdl/rtc_datetime_bcd_encoder.sv
`timescale 1ns / 1ps

// Converts one binary date/time beat (years 2000..2099) into the seven BCD
// bytes of an RTC time block: seconds, minutes, hour, weekday (Sunday = 0),
// day, month and two-digit year. Throughput is one beat per clock while the
// sink does not stall; each beat goes from the input register through the
// conversion logic into the result register.
// The output register lets a new beat be taken while a finished result
// waits; o_in_stall rises only when both registers are full and the sink
// stalls. hour_24 (reset 1) picks 24-hour coding (bit 7 set) or 12-hour
// coding with a PM flag in bit 5; write it over the cfg channel, which is
// always ready, and only while the block is empty. Inputs are not checked.

module rtc_datetime_bcd_encoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beats
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rtcbcd_pkg::t_in_item  i_in_item,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rtcbcd_pkg::t_out_item o_out_item,
    // hour system register
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_hour_24
);

    logic                  r_hour_24;
    logic                  r_in_valid;
    rtcbcd_pkg::t_in_item  r_in;
    logic                  r_out_valid;
    rtcbcd_pkg::t_out_item r_out;

    logic                  out_adv;   // result register free to load
    logic [2:0]            weekday;
    rtcbcd_pkg::t_out_item n_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_24 <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hour_24 <= i_cfg_hour_24;
        end
    end

    // Stage handshake: the input register drains whenever the result
    // register is empty or being taken this cycle.
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // conversion between the two registers
    rtcbcd_weekday u_weekday (
        .i_item    (r_in),
        .o_weekday (weekday)
    );

    rtcbcd_fields u_fields (
        .i_item    (r_in),
        .i_hour_24 (r_hour_24),
        .i_weekday (weekday),
        .o_item    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // upstream is held off only when the result register is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // a beat moving out of the input register shows up as a result next cycle
    a_beat_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_in_valid && out_adv)) |-> o_out_valid)
        else $error("beat lost between input and result registers");

    // weekday is always reduced below 7
    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.weekday_bcd != 3'd7))
        else $error("weekday not reduced mod 7");

    // 24-hour results carry the mode flag
    a_hour24_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_in_valid && out_adv && r_hour_24))
            |-> o_out_item.hour_code[7])
        else $error("24-hour flag missing");

    // low BCD digit of seconds never exceeds nine
    a_sec_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.second_bcd[3:0] <= 4'd9))
        else $error("seconds low digit out of BCD range");

endmodule

FILE: dv/rtcbcd_checker.sv
`timescale 1ns / 1ps

// Watches all three channels, predicts the time block for each accepted
// date/time beat and compares result beats in order.
module rtcbcd_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  rtcbcd_pkg::t_in_item  i_in_beat,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  rtcbcd_pkg::t_out_item i_out_beat,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic                  i_cfg_hour_24,
    output int unsigned           o_fail_count,
    output int unsigned           o_pending
);

    localparam int unsigned DAYS_BEFORE_MONTH [16] = '{
        0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
    };
    localparam int unsigned MAX_PRINTED = 100;

    rtcbcd_pkg::t_out_item expected_blocks [$];
    logic                  hour_24_mode = 1'b1;
    int unsigned           fail_count   = 0;

    assign o_fail_count = fail_count;

    function automatic int unsigned bcd_of(input int unsigned v);
        return v + 6 * (v / 10);
    endfunction

    function automatic rtcbcd_pkg::t_out_item encode_time_block(
            input rtcbcd_pkg::t_in_item dt, input logic mode_24);
        int unsigned           hr;
        int unsigned           yoff;
        int unsigned           days;
        int unsigned           hcode;
        rtcbcd_pkg::t_out_item blk;
        hr = dt.hour;
        if (mode_24)
            hcode = bcd_of(hr) | rtcbcd_pkg::HOUR_24_FLAG;
        else if (hr == 0)
            hcode = rtcbcd_pkg::HOUR_MIDNIGHT;
        else if (hr < rtcbcd_pkg::HOUR_TWELVE)
            hcode = bcd_of(hr);
        else if (hr == rtcbcd_pkg::HOUR_TWELVE)
            hcode = rtcbcd_pkg::HOUR_NOON;
        else if (hr < rtcbcd_pkg::HOUR_DAY_LEN)
            hcode = bcd_of(hr - rtcbcd_pkg::HOUR_TWELVE) | rtcbcd_pkg::HOUR_PM_FLAG;
        else
            hcode = rtcbcd_pkg::HOUR_BAD;
        // years below the base count from year 0, no wrap
        yoff = (dt.year >= rtcbcd_pkg::YEAR_BASE) ? dt.year - rtcbcd_pkg::YEAR_BASE
                                                  : dt.year;
        days = dt.day + DAYS_BEFORE_MONTH[dt.month] + 365 * yoff + (yoff + 3) / 4 + 5;
        if (dt.month > rtcbcd_pkg::MONTH_FEB && (yoff % 4) == 0)
            days++;
        blk.second_bcd  = 7'(bcd_of(dt.second));
        blk.minute_bcd  = 7'(bcd_of(dt.minute));
        blk.hour_code   = 8'(hcode);
        blk.weekday_bcd = 3'(days % 7);
        blk.day_bcd     = 6'(bcd_of(dt.day));
        blk.month_bcd   = 5'(bcd_of(dt.month));
        blk.year_bcd    = 8'(bcd_of((int'(dt.year) - int'(rtcbcd_pkg::YEAR_BASE)) & 8'hFF));
        return blk;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED)
            $display("%0t ns  rtc check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task automatic compare_block(input rtcbcd_pkg::t_out_item got,
                                 input rtcbcd_pkg::t_out_item want);
        check_field("second_bcd",  8'(got.second_bcd),  8'(want.second_bcd));
        check_field("minute_bcd",  8'(got.minute_bcd),  8'(want.minute_bcd));
        check_field("hour_code",   got.hour_code,       want.hour_code);
        check_field("weekday_bcd", 8'(got.weekday_bcd), 8'(want.weekday_bcd));
        check_field("day_bcd",     8'(got.day_bcd),     8'(want.day_bcd));
        check_field("month_bcd",   8'(got.month_bcd),   8'(want.month_bcd));
        check_field("year_bcd",    got.year_bcd,        want.year_bcd);
    endtask

    always @(posedge i_clk) begin : watch
        rtcbcd_pkg::t_out_item want;
        if (!i_rst_n) begin
            hour_24_mode = 1'b1;
            expected_blocks.delete();
            o_pending <= 0;
        end else begin
            // oldest first: a result can never belong to a beat taken this edge
            if (i_out_valid && !i_out_stall) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("result beat with no date/time waiting");
                end else begin
                    want = expected_blocks.pop_front();
                    compare_block(i_out_beat, want);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                hour_24_mode = i_cfg_hour_24;
            if (i_in_valid && !i_in_stall)
                expected_blocks.push_back(encode_time_block(i_in_beat, hour_24_mode));
            o_pending <= expected_blocks.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the RTC date/time encoder. Prediction and
// comparison live in the checker beside the block.
module tb_top;

    // receiver stall levels in percent; zero twice so quiet stretches are common
    localparam int unsigned STALL_LEVELS [5] = '{0, 0, 15, 40, 85};
    localparam int unsigned PHASE_BEATS      = 255;
    localparam int unsigned HOLD_CYCLES      = 40;
    localparam int unsigned IN_BITS          = $bits(rtcbcd_pkg::t_in_item);

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    rtcbcd_pkg::t_in_item  in_beat     = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    rtcbcd_pkg::t_out_item out_beat;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_hour_24 = 1'b1;
    logic                  hold_out_request = 1'b0;
    int unsigned           fail_count;
    int unsigned           pending;

    rtc_datetime_bcd_encoder uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_item     (in_beat),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (out_beat),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_hour_24 (cfg_hour_24)
    );

    rtcbcd_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_beat     (in_beat),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_beat    (out_beat),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_hour_24 (cfg_hour_24),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Hard stop, far past the slowest sane run.
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // Sender helpers. All drives are NBAs right after a rising edge, and
    // handshakes are read just after the edge, i.e. their pre-edge values.
    // ---------------------------------------------------------------

    function automatic rtcbcd_pkg::t_in_item date_time(input int unsigned y,
                                                       input int unsigned mo,
                                                       input int unsigned d,
                                                       input int unsigned h,
                                                       input int unsigned mi,
                                                       input int unsigned s);
        rtcbcd_pkg::t_in_item dt;
        dt.year   = 12'(y);
        dt.month  = 4'(mo);
        dt.day    = 5'(d);
        dt.hour   = 5'(h);
        dt.minute = 6'(mi);
        dt.second = 6'(s);
        return dt;
    endfunction

    // Mostly sensible dates inside the century; the rest raw bits, which
    // covers years below 2000, months 0/13..15, day 0, hours 24..31, 60..63.
    function automatic rtcbcd_pkg::t_in_item random_datetime();
        logic [IN_BITS-1:0] raw;
        if ($urandom_range(99) < 85)
            return date_time(rtcbcd_pkg::YEAR_BASE + $urandom_range(99),
                             $urandom_range(1, 12), $urandom_range(1, 31),
                             $urandom_range(23), $urandom_range(59), $urandom_range(59));
        raw = IN_BITS'({$urandom, $urandom});
        return raw;
    endfunction

    // Offer one beat; returns on the edge that takes it. Valid is left high
    // so a following beat goes out back to back.
    task automatic send_beat(input rtcbcd_pkg::t_in_item dt);
        in_valid <= 1'b1;
        in_beat  <= dt;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles != 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop offering and wait for the last result. pending is registered,
    // hence the edge before the first look.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // hour_24 may only change with the block empty. Every beat yields a
    // result, so once drained nothing is still in flight.
    task automatic set_hour_system(input logic mode_24);
        wait_drained();
        cfg_valid   <= 1'b1;
        cfg_hour_24 <= mode_24;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Bursts of random length, gaps of random length; now and then a long
    // burst with no gaps at all.
    task automatic run_random_phase(input int unsigned beats);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < beats) begin
            burst = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < beats; i++) begin
                send_beat(random_datetime());
                sent++;
            end
            idle_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12));
        end
    endtask

    // Receiver shuts for a long stretch while beats keep coming, so both
    // block registers fill and the input stalls; then let it drain fully.
    // The request is a one-cycle pulse seen by the receiver at the next edge.
    task automatic back_pressure_burst();
        in_valid         <= 1'b0;
        hold_out_request <= 1'b1;
        @(posedge clk);
        hold_out_request <= 1'b0;
        repeat (24) send_beat(random_datetime());
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall level is redrawn each time a random countdown ends; on
    // request it holds off for HOLD_CYCLES, counted here.
    // ---------------------------------------------------------------
    initial begin : receiver
        int unsigned pct;
        int unsigned left;
        pct  = 0;
        left = 0;
        forever begin
            @(posedge clk);
            if (hold_out_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (left == 0) begin
                    left = $urandom_range(20, 200);
                    pct  = STALL_LEVELS[$urandom_range(4)];
                end
                left--;
                out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // 24-hour coding straight out of reset
        send_beat(date_time(2000, 1, 1, 0, 0, 0));        // first day of the century
        send_beat(date_time(2099, 12, 31, 23, 59, 59));   // last second of it
        send_beat(date_time(2000, 2, 29, 12, 30, 45));    // leap day
        send_beat(date_time(2000, 3, 1, 7, 8, 9));        // after a leap day
        send_beat(date_time(2001, 3, 1, 10, 20, 30));     // common year
        send_beat(date_time(2004, 2, 28, 19, 45, 15));
        send_beat(date_time(1999, 12, 31, 23, 59, 59));   // year below base
        send_beat(date_time(0, 0, 0, 0, 0, 0));           // every field zero
        send_beat(date_time(4095, 15, 31, 31, 63, 63));   // every field all ones
        send_beat(date_time(2100, 13, 15, 24, 60, 61));   // month 13, hour 24, min/sec 60+
        send_beat(date_time(2050, 14, 0, 27, 10, 19));    // day 0
        send_beat(date_time(2256, 2, 9, 31, 9, 9));       // year byte wraps to 0
        send_beat(date_time(2199, 1, 1, 16, 1, 2));

        // 12-hour coding: midnight, morning, noon, afternoon, beyond a day
        set_hour_system(1'b0);
        send_beat(date_time(2023, 6, 15, 0, 0, 0));
        send_beat(date_time(2023, 6, 15, 1, 2, 3));
        send_beat(date_time(2023, 6, 15, 11, 59, 59));
        send_beat(date_time(2024, 7, 4, 12, 0, 0));
        send_beat(date_time(2024, 7, 4, 13, 14, 15));
        send_beat(date_time(2024, 12, 25, 23, 59, 59));
        send_beat(date_time(2010, 10, 10, 24, 10, 10));
        send_beat(date_time(2011, 11, 11, 31, 11, 11));

        // random phases, alternating the hour system
        for (int p = 0; p < 6; p++) begin
            set_hour_system((p % 2) == 0);
            run_random_phase(PHASE_BEATS);
            if (p == 2)
                back_pressure_burst();
        end

        // settle, then keep watching to catch any stray result beat
        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
